// ===== rtl/rgbhsl_pkg.sv =====
// Shared widths, payload structs and the divider pipeline record for the
// RGB to HSL converter. No dependencies.
`timescale 1ns / 1ps
package rgbhsl_pkg;
	localparam int CHANNEL_BITS = 8;
	localparam int CMAX = (1 << CHANNEL_BITS) - 1;
	// Quotient bits: every result stays below 1024.
	localparam int QB = 10;
	// Dividend width covers 1000 * 2 * CMAX and 720 * delta + delta.
	localparam int DW = CHANNEL_BITS + 11;
	// Divisor width covers 2 * CMAX.
	localparam int VW = CHANNEL_BITS + 1;
	// Signed width for the hue numerator.
	localparam int SW = CHANNEL_BITS + 12;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [8:0] hue_degrees;
		logic [9:0] saturation_tenths;
		logic [9:0] lightness_tenths;
	} hsl_t;

	// One item in flight through the divider chain: three divisions side by side.
	typedef struct packed {
		logic          grey;
		logic [DW-1:0] hue_rem;
		logic [DW-1:0] sat_rem;
		logic [DW-1:0] lit_rem;
		logic [VW-1:0] hue_div;
		logic [VW-1:0] sat_div;
		logic [VW-1:0] lit_div;
		logic [QB-1:0] hue_q;
		logic [QB-1:0] sat_q;
		logic [QB-1:0] lit_q;
	} div_data_t;
endpackage

// ===== rtl/rgbhsl_cell.sv =====
// One cell of the divider chain: settles one quotient bit of the hue,
// saturation and lightness divisions. Depends on rgbhsl_pkg.
`timescale 1ns / 1ps
module rgbhsl_cell #(
	parameter int BIT = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_in,
	input  rgbhsl_pkg::div_data_t  data_in,
	output logic                   valid_out,
	output rgbhsl_pkg::div_data_t  data_out
);
	logic [rgbhsl_pkg::DW-1:0] hue_sh, sat_sh, lit_sh;
	rgbhsl_pkg::div_data_t next;
	logic valid_q;
	rgbhsl_pkg::div_data_t data_q;

	assign hue_sh = rgbhsl_pkg::DW'(data_in.hue_div) << BIT;
	assign sat_sh = rgbhsl_pkg::DW'(data_in.sat_div) << BIT;
	assign lit_sh = rgbhsl_pkg::DW'(data_in.lit_div) << BIT;

	always_comb begin
		next = data_in;
		if (data_in.hue_rem >= hue_sh) begin
			next.hue_rem = data_in.hue_rem - hue_sh;
			next.hue_q[BIT] = 1'b1;
		end
		if (data_in.sat_rem >= sat_sh) begin
			next.sat_rem = data_in.sat_rem - sat_sh;
			next.sat_q[BIT] = 1'b1;
		end
		if (data_in.lit_rem >= lit_sh) begin
			next.lit_rem = data_in.lit_rem - lit_sh;
			next.lit_q[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= next;
	end

	assign valid_out = valid_q;
	assign data_out  = data_q;
endmodule

// ===== rtl/rgb_to_hsl_converter_core.sv =====
// Top level of the RGB to HSL converter: front end for max, min and the
// numerators, then a chain of rgbhsl_cell stages. Depends on rgbhsl_pkg.
`timescale 1ns / 1ps
// The converter takes one pixel on every clock: busy is always low, so an item
// is accepted whenever start is high. Each result is held on result with done
// high for one cycle, after passing through two front-end register stages and
// ten divider cells, one per quotient bit, which give twelve registers in the
// path. The receiver cannot stall, and none is needed, since results leave in
// order at the input rate.
module rgb_to_hsl_converter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rgbhsl_pkg::pixel_t pixel,
	output logic               done,
	output rgbhsl_pkg::hsl_t   result
);
	localparam int N = rgbhsl_pkg::CHANNEL_BITS;
	localparam int SW = rgbhsl_pkg::SW;
	localparam int DW = rgbhsl_pkg::DW;
	localparam int VW = rgbhsl_pkg::VW;
	localparam int QB = rgbhsl_pkg::QB;

	logic               vld_s1;
	rgbhsl_pkg::pixel_t pix_s1;
	logic [N-1:0] mx, mn;
	logic [N-1:0] delta;
	logic [N:0]   sum;
	logic signed [SW-1:0] rs, gs, bs, ds, t, num;
	rgbhsl_pkg::div_data_t front;
	logic                  vld_s2;
	rgbhsl_pkg::div_data_t data_s2;
	logic                  vchain [QB+1];
	rgbhsl_pkg::div_data_t dchain [QB+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1  <= pixel;
		data_s2 <= front;
	end

	always_comb begin
		mx = pix_s1.red;
		mn = pix_s1.red;
		if (pix_s1.green > mx) mx = pix_s1.green;
		if (pix_s1.blue > mx) mx = pix_s1.blue;
		if (pix_s1.green < mn) mn = pix_s1.green;
		if (pix_s1.blue < mn) mn = pix_s1.blue;
		delta = mx - mn;
		sum = (N+1)'(mx) + (N+1)'(mn);
		rs = SW'(pix_s1.red);
		gs = SW'(pix_s1.green);
		bs = SW'(pix_s1.blue);
		ds = SW'(delta);
		// Red wins a tie for the maximum, then green.
		if (pix_s1.red == mx) begin
			t = gs - bs;
		end else if (pix_s1.green == mx) begin
			t = (ds <<< 1) + bs - rs;
		end else begin
			t = (ds <<< 2) + rs - gs;
		end
		num = SW'(60) * t;
		if (num < 0) begin
			num = num + SW'(360) * ds;
		end
		front = '0;
		front.grey    = (delta == '0);
		// Round half up: floor((2*num + delta) / (2*delta)).
		front.hue_rem = DW'((num <<< 1) + ds);
		front.hue_div = VW'(delta) << 1;
		front.sat_rem = DW'(delta) * DW'(1000);
		front.sat_div = (sum <= VW'(rgbhsl_pkg::CMAX)) ? sum :
			VW'(2 * rgbhsl_pkg::CMAX) - sum;
		front.lit_rem = DW'(sum) * DW'(1000);
		front.lit_div = VW'(2 * rgbhsl_pkg::CMAX);
	end

	assign vchain[0] = vld_s2;
	assign dchain[0] = data_s2;

	for (genvar i = 0; i < QB; i++) begin : g_cell
		rgbhsl_cell #(.BIT(QB - 1 - i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (vchain[i]),
			.data_in  (dchain[i]),
			.valid_out(vchain[i+1]),
			.data_out (dchain[i+1])
		);
	end

	assign done = vchain[QB];

	always_comb begin
		result.hue_degrees       = dchain[QB].grey ? 9'd0 : dchain[QB].hue_q[8:0];
		result.saturation_tenths = dchain[QB].grey ? 10'd0 : dchain[QB].sat_q;
		result.lightness_tenths  = dchain[QB].lit_q;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, QB + 2))
		else $error("result without a matching item");
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.hue_degrees <= 9'd360)
		else $error("hue out of range");
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.saturation_tenths <= 10'd1000)
		else $error("saturation out of range");
	a_lit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.lightness_tenths <= 10'd1000)
		else $error("lightness out of range");
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dchain[QB].grey) |-> result.saturation_tenths == 10'd0)
		else $error("grey pixel with saturation");
endmodule
